// ===== sv/bole_pkg.sv =====
// Shared types, widths and codes of the bounded ordered list engine.
`timescale 1ns / 1ps
package bole_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int REQ_W    = 3;
  localparam int POS_W    = 5;
  localparam int STAT_W   = 3;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND  = 3'd0,
    REQ_PREPEND = 3'd1,
    REQ_INSERT  = 3'd2,
    REQ_REVERSE = 3'd3,
    REQ_REMOVE  = 3'd4,
    REQ_DUMP    = 3'd5
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE   = 3'd0,
    STAT_ITEM   = 3'd1,
    STAT_BADPOS = 3'd2,
    STAT_FULL   = 3'd3,
    STAT_EMPTY  = 3'd4
  } status_e;

  // hold; insert (above sel take left, at sel take ins);
  // pop (take right); rotate (below sel take right, at sel take head)
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_INS  = 2'd1,
    OP_POP  = 2'd2,
    OP_ROT  = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [IDX_W-1:0]  sel;
    logic [DATA_W-1:0] ins;
  } cell_ctl_t;

endpackage

// ===== sv/bounded_ordered_list_engine.sv =====
// Top level: request decode, list control and result register.
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells.
// Append, prepend, insert, remove head and every error case give one beat.
// Reverse gives its beat at once but keeps the input stalled until done,
// one head-to-slot rotation per cycle. Dump gives one beat per element,
// head first, one per cycle while the output is not stalled, rotating the
// row so it ends unchanged. A new request is taken when no reverse or dump
// runs and the result register is free or being drained.
module bounded_ordered_list_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 req_type_i,
  input  logic signed [31:0]         data_value_i,
  input  logic [4:0]                 position_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 status_o,
  output logic signed [31:0]         item_data_o,
  output logic                       last_of_run_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_REV  = 3'b010,
    ST_DUMP = 3'b100
  } state_e;

  state_e                        state_q, state_d;
  logic [bole_pkg::CNT_W-1:0]    count_q, count_d;
  logic [bole_pkg::CNT_W-1:0]    rem_q, rem_d;
  logic [bole_pkg::IDX_W-1:0]    k_q, k_d;
  logic                          out_valid_q, out_valid_d;
  bole_pkg::status_e             status_q, status_d;
  logic [bole_pkg::DATA_W-1:0]   data_q, data_d;
  logic                          last_q, last_d;

  bole_pkg::cell_ctl_t           ctl;
  logic [bole_pkg::DATA_W-1:0]   head;
  logic                          out_free, accept, load, full, empty;
  logic [bole_pkg::CMP_W-1:0]    pos_ext, cnt_ext;
  logic [bole_pkg::CNT_W-1:0]    cnt_m1;

  bole_row u_row (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .head_o (head)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q >= bole_pkg::CNT_W'(bole_pkg::CAPACITY));
  assign empty      = (count_q == '0);
  assign pos_ext    = bole_pkg::CMP_W'(position_i);
  assign cnt_ext    = bole_pkg::CMP_W'(count_q);
  assign cnt_m1     = count_q - bole_pkg::CNT_W'(1);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rem_d    = rem_q;
    k_d      = k_q;
    ctl.op   = bole_pkg::OP_HOLD;
    ctl.sel  = '0;
    ctl.ins  = data_value_i;
    load     = 1'b0;
    status_d = bole_pkg::STAT_DONE;
    data_d   = '0;
    last_d   = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          load = 1'b1;
          unique case (bole_pkg::req_e'(req_type_i))
            bole_pkg::REQ_APPEND: begin
              if (full) begin
                status_d = bole_pkg::STAT_FULL;
              end else begin
                ctl.op  = bole_pkg::OP_INS;
                ctl.sel = bole_pkg::IDX_W'(count_q);
                count_d = count_q + bole_pkg::CNT_W'(1);
              end
            end
            bole_pkg::REQ_PREPEND: begin
              if (full) begin
                status_d = bole_pkg::STAT_FULL;
              end else begin
                ctl.op  = bole_pkg::OP_INS;
                count_d = count_q + bole_pkg::CNT_W'(1);
              end
            end
            bole_pkg::REQ_INSERT: begin
              if (pos_ext > cnt_ext) begin
                status_d = bole_pkg::STAT_BADPOS;
              end else if (full) begin
                status_d = bole_pkg::STAT_FULL;
              end else begin
                ctl.op  = bole_pkg::OP_INS;
                ctl.sel = bole_pkg::IDX_W'(pos_ext);
                count_d = count_q + bole_pkg::CNT_W'(1);
              end
            end
            bole_pkg::REQ_REVERSE: begin
              if (count_q > bole_pkg::CNT_W'(1)) begin
                state_d = ST_REV;
                k_d     = bole_pkg::IDX_W'(cnt_m1);
              end
            end
            bole_pkg::REQ_REMOVE: begin
              if (empty) begin
                status_d = bole_pkg::STAT_EMPTY;
              end else begin
                ctl.op  = bole_pkg::OP_POP;
                count_d = cnt_m1;
              end
            end
            bole_pkg::REQ_DUMP: begin
              if (empty) begin
                status_d = bole_pkg::STAT_EMPTY;
              end else begin
                load    = 1'b0;
                state_d = ST_DUMP;
                rem_d   = count_q;
              end
            end
            default: begin
              status_d = bole_pkg::STAT_DONE;
            end
          endcase
        end
      end
      ST_REV: begin
        ctl.op  = bole_pkg::OP_ROT;
        ctl.sel = k_q;
        k_d     = k_q - bole_pkg::IDX_W'(1);
        if (k_q == bole_pkg::IDX_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          ctl.op   = bole_pkg::OP_ROT;
          ctl.sel  = bole_pkg::IDX_W'(cnt_m1);
          load     = 1'b1;
          status_d = bole_pkg::STAT_ITEM;
          data_d   = head;
          last_d   = (rem_q == bole_pkg::CNT_W'(1));
          rem_d    = rem_q - bole_pkg::CNT_W'(1);
          if (rem_q == bole_pkg::CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= status_d;
      data_q   <= data_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign item_data_o   = data_q;
  assign last_of_run_o = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bole_pkg::CNT_W'(bole_pkg::CAPACITY))
    else $error("element count above capacity");

  a_count_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |=> count_q == $past(count_q))
    else $error("element count changed during reverse or dump");

  a_dump_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP && out_free && rem_q == bole_pkg::CNT_W'(1))
      |=> (state_q == ST_IDLE && out_valid_q && last_q))
    else $error("dump did not close with a final beat");

  a_rev_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REV) |-> (k_q != '0 && in_stall_o))
    else $error("reverse step out of range or input open");

endmodule

// ===== sv/bole_cell.sv =====
// One list slot: holds an element and moves it to or from its neighbors.
`timescale 1ns / 1ps
module bole_cell (
  input  logic                           clk_i,
  input  bole_pkg::cell_ctl_t            ctl_i,
  input  logic [bole_pkg::IDX_W-1:0]     idx_i,
  input  logic [bole_pkg::DATA_W-1:0]    left_i,
  input  logic [bole_pkg::DATA_W-1:0]    right_i,
  input  logic [bole_pkg::DATA_W-1:0]    head_i,
  output logic [bole_pkg::DATA_W-1:0]    value_o
);

  logic [bole_pkg::DATA_W-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    case (ctl_i.op)
      bole_pkg::OP_INS: begin
        if (idx_i > ctl_i.sel) begin
          value_d = left_i;
        end else if (idx_i == ctl_i.sel) begin
          value_d = ctl_i.ins;
        end
      end
      bole_pkg::OP_POP: begin
        value_d = right_i;
      end
      bole_pkg::OP_ROT: begin
        if (idx_i < ctl_i.sel) begin
          value_d = right_i;
        end else if (idx_i == ctl_i.sel) begin
          value_d = head_i;
        end
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ===== sv/bole_row.sv =====
// Row of list cells, head at index 0, chained to their neighbors.
`timescale 1ns / 1ps
module bole_row (
  input  logic                        clk_i,
  input  bole_pkg::cell_ctl_t         ctl_i,
  output logic [bole_pkg::DATA_W-1:0] head_o
);

  logic [bole_pkg::DATA_W-1:0] val [bole_pkg::CAPACITY];

  for (genvar g = 0; g < bole_pkg::CAPACITY; g++) begin : g_cell
    logic [bole_pkg::DATA_W-1:0] left, right;

    if (g == 0) begin : g_first
      assign left = val[g];
    end else begin : g_mid_l
      assign left = val[g-1];
    end

    if (g == bole_pkg::CAPACITY - 1) begin : g_last
      assign right = val[g];
    end else begin : g_mid_r
      assign right = val[g+1];
    end

    bole_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl_i),
      .idx_i   (bole_pkg::IDX_W'(g)),
      .left_i  (left),
      .right_i (right),
      .head_i  (val[0]),
      .value_o (val[g])
    );
  end

  assign head_o = val[0];

endmodule

// ===== sim/bounded_ordered_list_engine_chk.sv =====
// Checker for the list engine: models the list, predicts result beats and compares them.
`timescale 1ns / 1ps
module bounded_ordered_list_engine_chk
  import bole_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_o,
  input  logic [REQ_W-1:0]         req_type_i,
  input  logic signed [DATA_W-1:0] data_value_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic                     out_valid_o,
  input  logic                     out_stall_i,
  input  logic [STAT_W-1:0]        status_o,
  input  logic signed [DATA_W-1:0] item_data_o,
  input  logic                     last_of_run_o,
  output int                       fail_cnt_o,
  output int                       pending_o,
  output int                       req_cnt_o,
  output int                       beat_cnt_o
);

  typedef struct {
    status_e                  status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } list_result_t;

  logic signed [DATA_W-1:0] list_vals [CAPACITY];
  int                       list_len;
  list_result_t             awaited_q [$];
  list_result_t             oldest;

  task automatic report_mismatch(string msg);
    fail_cnt_o++;
    $display("%0t ns: mismatch at beat %0d: %s", $time, beat_cnt_o, msg);
  endtask

  task automatic expect_beat(status_e st, logic signed [DATA_W-1:0] d, logic l);
    list_result_t r;
    r.status = st;
    r.data   = d;
    r.last   = l;
    awaited_q.insert(awaited_q.size(), r);
  endtask

  task automatic place_value(int idx, logic signed [DATA_W-1:0] v);
    int k;
    for (k = list_len; k > idx; k--) list_vals[k] = list_vals[k-1];
    list_vals[idx] = v;
    list_len++;
  endtask

  task automatic apply_request(logic [REQ_W-1:0] req, logic signed [DATA_W-1:0] v,
                               logic [POS_W-1:0] pos);
    logic signed [DATA_W-1:0] t;
    int                       k;
    case (req)
      REQ_APPEND, REQ_PREPEND: begin
        if (list_len >= CAPACITY) begin
          expect_beat(STAT_FULL, '0, 1'b1);
        end else begin
          place_value((req == REQ_APPEND) ? list_len : 0, v);
          expect_beat(STAT_DONE, '0, 1'b1);
        end
      end
      REQ_INSERT: begin
        // position is checked before capacity
        if (pos > list_len) begin
          expect_beat(STAT_BADPOS, '0, 1'b1);
        end else if (list_len >= CAPACITY) begin
          expect_beat(STAT_FULL, '0, 1'b1);
        end else begin
          place_value(int'(pos), v);
          expect_beat(STAT_DONE, '0, 1'b1);
        end
      end
      REQ_REVERSE: begin
        for (k = 0; k < list_len / 2; k++) begin
          t                       = list_vals[k];
          list_vals[k]            = list_vals[list_len-1-k];
          list_vals[list_len-1-k] = t;
        end
        expect_beat(STAT_DONE, '0, 1'b1);
      end
      REQ_REMOVE: begin
        if (list_len == 0) begin
          expect_beat(STAT_EMPTY, '0, 1'b1);
        end else begin
          for (k = 1; k < list_len; k++) list_vals[k-1] = list_vals[k];
          list_len--;
          expect_beat(STAT_DONE, '0, 1'b1);
        end
      end
      REQ_DUMP: begin
        if (list_len == 0) begin
          expect_beat(STAT_EMPTY, '0, 1'b1);
        end else begin
          for (k = 0; k < list_len; k++) expect_beat(STAT_ITEM, list_vals[k], k == list_len - 1);
        end
      end
      default: expect_beat(STAT_DONE, '0, 1'b1);
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      awaited_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
      req_cnt_o  = 0;
      beat_cnt_o = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        apply_request(req_type_i, data_value_i, position_i);
        req_cnt_o++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (awaited_q.size() == 0) begin
          report_mismatch($sformatf("beat with nothing pending, status %0d", status_o));
        end else begin
          oldest = awaited_q.pop_front();
          if (status_o !== oldest.status)
            report_mismatch($sformatf("status expected %0d got %0d", oldest.status, status_o));
          if (item_data_o !== oldest.data)
            report_mismatch($sformatf("item_data expected %0h got %0h", oldest.data,
                                      item_data_o));
          if (last_of_run_o !== oldest.last)
            report_mismatch($sformatf("last_of_run expected %0b got %0b", oldest.last,
                                      last_of_run_o));
        end
        beat_cnt_o++;
      end
      pending_o = awaited_q.size();
    end
  end

endmodule

// ===== sim/bounded_ordered_list_engine_tb.sv =====
// Testbench top for the list engine: request and stall stimulus, verdict.
`timescale 1ns / 1ps
module bounded_ordered_list_engine_tb;
  import bole_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
  localparam int               POS_MAX      = (1 << POS_W) - 1;
  localparam int               HOLD_CYCLES  = 80;
  localparam int               DRAIN_CYCLES = 4 * CAPACITY;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_stall_o;
  logic [REQ_W-1:0]         req_type_i   = '0;
  logic signed [DATA_W-1:0] data_value_i = '0;
  logic [POS_W-1:0]         position_i   = '0;
  logic                     out_valid_o;
  logic                     out_stall_i  = 1'b0;
  logic [STAT_W-1:0]        status_o;
  logic signed [DATA_W-1:0] item_data_o;
  logic                     last_of_run_o;

  int fail_cnt;
  int pending;
  int req_cnt;
  int beat_cnt;
  bit hold_req = 1'b0;
  bit calm     = 1'b0;

  always #6 clk_i = ~clk_i;

  bounded_ordered_list_engine dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .data_value_i, .position_i,
    .out_valid_o, .out_stall_i, .status_o, .item_data_o, .last_of_run_o
  );

  bounded_ordered_list_engine_chk u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .data_value_i  (data_value_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .item_data_o   (item_data_o),
    .last_of_run_o (last_of_run_o),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .req_cnt_o     (req_cnt),
    .beat_cnt_o    (beat_cnt)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r >= 10) return $urandom();
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0000;
    endcase
  endfunction

  task automatic send_req(logic [REQ_W-1:0] req, logic [DATA_W-1:0] v, logic [POS_W-1:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    data_value_i <= v;
    position_i   <= pos;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic random_req(int grow_pct);
    int               r;
    logic [REQ_W-1:0] req;
    logic [POS_W-1:0] pos;
    r = $urandom_range(0, 99);
    if (r < grow_pct) begin
      r = $urandom_range(0, 3);
      req = (r == 0) ? REQ_APPEND : (r == 1) ? REQ_PREPEND : REQ_INSERT;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50)      req = REQ_REMOVE;
      else if (r < 75) req = REQ_DUMP;
      else if (r < 95) req = REQ_REVERSE;
      else             req = (r < 98) ? REQ_SPARE_LO : REQ_SPARE_HI;
    end
    if ($urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, CAPACITY));
    else                            pos = POS_W'($urandom_range(CAPACITY + 1, POS_MAX));
    send_req(req, pick_value(), pos);
  endtask

  task automatic run_phase(int count, int grow_pct);
    int n;
    for (n = 0; n < count; n++) random_req(grow_pct);
  endtask

  // stop offering, let the last accepted request reach the checker, then wait until nothing is pending
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // result side stall pattern; a hold request forces one long stall
  initial begin : stall_gen
    int run;
    bit stall_nxt;
    run = 0;
    forever begin
      @(posedge clk_i);
      if (run > 0) begin
        run--;
      end else begin
        if (hold_req) begin
          hold_req  = 1'b0;
          stall_nxt = 1'b1;
          run       = HOLD_CYCLES;
        end else if (calm) begin
          stall_nxt = 1'b0;
        end else begin
          stall_nxt = $urandom_range(0, 99) < 35;
          run       = pick_gap();
        end
        out_stall_i <= stall_nxt;
      end
    end
  end

  initial begin : stim
    int k;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list, single element, bad positions, spare codes
    send_req(REQ_DUMP, pick_value(), '0);
    send_req(REQ_REMOVE, pick_value(), '0);
    send_req(REQ_REVERSE, pick_value(), '0);
    send_req(REQ_INSERT, pick_value(), 5'd1);
    send_req(REQ_INSERT, 32'h7FFF_FFFF, 5'd0);
    send_req(REQ_REVERSE, pick_value(), '0);
    send_req(REQ_PREPEND, 32'h8000_0000, '0);
    send_req(REQ_APPEND, 32'hFFFF_FFFF, '0);
    send_req(REQ_INSERT, pick_value(), 5'd16);
    send_req(REQ_SPARE_LO, pick_value(), '0);
    send_req(REQ_SPARE_HI, pick_value(), '0);
    send_req(REQ_REVERSE, pick_value(), '0);
    send_req(REQ_DUMP, pick_value(), '0);
    send_req(REQ_REMOVE, pick_value(), '0);

    // fill to capacity, then hit the full cases and a bad position on a full list
    for (k = 2; k < CAPACITY; k++)
      send_req(REQ_INSERT, pick_value(), POS_W'($urandom_range(0, k)));
    send_req(REQ_APPEND, pick_value(), '0);
    send_req(REQ_PREPEND, pick_value(), '0);
    send_req(REQ_INSERT, pick_value(), 5'd16);
    send_req(REQ_INSERT, pick_value(), 5'(POS_MAX));
    send_req(REQ_DUMP, pick_value(), '0);

    hold_req = 1'b1;
    run_phase(80, 75);
    wait_drained();
    run_phase(120, 50);
    wait_drained();
    run_phase(70, 25);
    hold_req = 1'b1;
    run_phase(80, 70);
    calm = 1'b1;
    run_phase(50, 50);
    calm = 1'b0;
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Run covered %0d requests and %0d result beats: empty, single, full and",
             req_cnt, beat_cnt);
    $display("bad-position lists, spare codes, long result stalls and back-to-back beats.");
    if (fail_cnt == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Timeout with %0d results still pending", pending);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bole_pkg.sv
sv/bole_cell.sv
sv/bole_row.sv
sv/bounded_ordered_list_engine.sv
sim/bounded_ordered_list_engine_chk.sv
sim/bounded_ordered_list_engine_tb.sv
